// ===== rtl/ciap_pkg.sv =====
// ----------------------------------------------------------------------------
// ciap_pkg
// types, codes and sizes shared by the checked alu with power
// ----------------------------------------------------------------------------
package ciap_pkg;

  localparam int DATA_WIDTH_DEF  = 64;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int MAG_W           = 64;
  localparam int PROD_W          = 2 * MAG_W;
  localparam int MUL_CHUNK       = 16;
  localparam int MUL_STEPS       = MAG_W / MUL_CHUNK;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_POW = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVF     = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic             invalid;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
  } item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_MUL_CHK,
    BK_PLOOP,
    BK_PACC,
    BK_PACC_CHK,
    BK_PSHIFT,
    BK_PSQ,
    BK_PSQ_CHK,
    BK_FIN
  } back_state_t;

endpackage

// ===== rtl/ciap_req_if.sv =====
// ----------------------------------------------------------------------------
// ciap_req_if
// request channel: opcode and two operands
// ----------------------------------------------------------------------------
interface ciap_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] operand_a;
  logic [63:0] operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input opcode, input operand_a, input operand_b,
                output ready);
endinterface

// ===== rtl/ciap_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ciap_rsp_if
// response channel: result value and status
// ----------------------------------------------------------------------------
interface ciap_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic [1:0]  status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink (input valid, input result_value, input status, output ready);
endinterface

// ===== rtl/ciap_front.sv =====
// ----------------------------------------------------------------------------
// ciap_front
// takes request words, sign-extends the operands and flags bad power operands
// ----------------------------------------------------------------------------
module ciap_front #(
  parameter int DATA_WIDTH = ciap_pkg::DATA_WIDTH_DEF
) (
  ciap_req_if.sink         req,
  output logic             push_valid,
  input  logic             push_ready,
  output ciap_pkg::item_t  push_item
);
  import ciap_pkg::*;

  localparam int SHIFT = MAG_W - DATA_WIDTH;

  logic signed [MAG_W-1:0] a_ext;
  logic signed [MAG_W-1:0] b_ext;
  op_t                     op;

  assign a_ext = $signed(req.operand_a << SHIFT) >>> SHIFT;
  assign b_ext = $signed(req.operand_b << SHIFT) >>> SHIFT;
  assign op    = op_t'(req.opcode);

  assign push_valid        = req.valid;
  assign req.ready         = push_ready;
  assign push_item.op      = op;
  assign push_item.a       = a_ext;
  assign push_item.b       = b_ext;
  assign push_item.invalid = (op == OP_POW) &&
                             (b_ext[MAG_W-1] || ((a_ext == '0) && (b_ext == '0)));

endmodule

// ===== rtl/ciap_queue.sv =====
// ----------------------------------------------------------------------------
// ciap_queue
// short queue of classified words between front and back
// ----------------------------------------------------------------------------
module ciap_queue #(
  parameter int DEPTH = ciap_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  ciap_pkg::item_t  push_item,
  output logic             pop_valid,
  input  logic             pop,
  output ciap_pkg::item_t  pop_item
);
  import ciap_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/ciap_back.sv =====
// ----------------------------------------------------------------------------
// ciap_back
// executes words: add and subtract at once, multiply and power through a
// shared 64x16 multiplier with exact range checks
// ----------------------------------------------------------------------------
module ciap_back #(
  parameter int DATA_WIDTH = ciap_pkg::DATA_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  ciap_pkg::item_t  head,
  output logic             pop,
  ciap_rsp_if.source       rsp
);
  import ciap_pkg::*;

  localparam int CNT_W = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;
  localparam logic signed [MAG_W:0] SUM_MAX = ((MAG_W+1)'(1) <<< (DATA_WIDTH - 1)) -
                                              (MAG_W+1)'(1);
  localparam logic signed [MAG_W:0] SUM_MIN = -((MAG_W+1)'(1) <<< (DATA_WIDTH - 1));
  localparam logic [PROD_W-1:0]     HALF    = PROD_W'(1) << (DATA_WIDTH - 1);

  back_state_t state, state_next;

  logic                  a_neg, b_neg;
  logic [MAG_W-1:0]      a_mag, b_mag;
  logic signed [MAG_W:0] sum;
  logic                  sum_fits;
  logic                  quick;
  logic                  out_free;
  logic                  write_quick;
  logic                  write_fin;

  logic [MAG_W-1:0]           mx, my;
  logic                       mxn, myn;
  logic [CNT_W-1:0]           cnt;
  logic [PROD_W-1:0]          pacc;
  logic [MAG_W+MUL_CHUNK-1:0] pp;
  logic                       mul_last;
  logic                       prod_neg;
  logic                       prod_fits;
  logic [MAG_W-1:0]           prod_val;

  logic [MAG_W-1:0] acc, base, e;
  logic             acc_neg, base_neg;
  logic [MAG_W-1:0] acc_val;
  logic [MAG_W-1:0] fin_value;
  status_t          fin_status;

  logic [MAG_W-1:0] out_value;
  status_t          out_status;
  logic             out_valid;

  assign a_neg = head.a[MAG_W-1];
  assign b_neg = head.b[MAG_W-1];
  assign a_mag = a_neg ? -head.a : head.a;
  assign b_mag = b_neg ? -head.b : head.b;

  always_comb begin
    case (head.op)
      OP_SUB:  sum = $signed({head.a[MAG_W-1], head.a}) - $signed({head.b[MAG_W-1], head.b});
      default: sum = $signed({head.a[MAG_W-1], head.a}) + $signed({head.b[MAG_W-1], head.b});
    endcase
  end

  assign sum_fits = (sum >= SUM_MIN) && (sum <= SUM_MAX);
  assign quick    = head.invalid || (head.op == OP_ADD) || (head.op == OP_SUB);
  assign out_free = !out_valid || rsp.ready;

  assign pp        = mx * my[MAG_W-1 -: MUL_CHUNK];
  assign mul_last  = (cnt == CNT_W'(MUL_STEPS - 1));
  assign prod_neg  = (mxn ^ myn) && (pacc != '0);
  assign prod_fits = prod_neg ? (pacc <= HALF) : (pacc < HALF);
  assign prod_val  = prod_neg ? -pacc[MAG_W-1:0] : pacc[MAG_W-1:0];
  assign acc_val   = acc_neg ? -acc : acc;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (head_valid && (!quick || out_free)) begin
          if (quick) begin
            state_next = BK_IDLE;
          end else if (head.op == OP_MUL) begin
            state_next = BK_MUL;
          end else begin
            state_next = BK_PLOOP;
          end
        end
      end
      BK_MUL: begin
        if (mul_last) state_next = BK_MUL_CHK;
      end
      BK_MUL_CHK: state_next = BK_FIN;
      BK_PLOOP: begin
        if (e == '0) begin
          state_next = BK_FIN;
        end else if (e[0]) begin
          state_next = BK_PACC;
        end else begin
          state_next = BK_PSHIFT;
        end
      end
      BK_PACC: begin
        if (mul_last) state_next = BK_PACC_CHK;
      end
      BK_PACC_CHK: state_next = prod_fits ? BK_PSHIFT : BK_FIN;
      BK_PSHIFT: state_next = (e[MAG_W-1:1] != '0) ? BK_PSQ : BK_PLOOP;
      BK_PSQ: begin
        if (mul_last) state_next = BK_PSQ_CHK;
      end
      BK_PSQ_CHK: state_next = prod_fits ? BK_PLOOP : BK_FIN;
      BK_FIN: begin
        if (out_free) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop         = 1'b0;
    write_quick = 1'b0;
    write_fin   = 1'b0;
    case (state)
      BK_IDLE: begin
        pop         = head_valid && (!quick || out_free);
        write_quick = head_valid && quick && out_free;
      end
      BK_FIN: write_fin = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (write_quick || write_fin) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write_quick) begin
      if (head.invalid) begin
        out_value  <= '0;
        out_status <= ST_INVALID;
      end else if (sum_fits) begin
        out_value  <= sum[MAG_W-1:0];
        out_status <= ST_OK;
      end else begin
        out_value  <= '0;
        out_status <= ST_OVF;
      end
    end else if (write_fin) begin
      out_value  <= fin_value;
      out_status <= fin_status;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop && !quick) begin
          mx       <= a_mag;
          my       <= b_mag;
          mxn      <= a_neg;
          myn      <= b_neg;
          cnt      <= '0;
          pacc     <= '0;
          acc      <= MAG_W'(1);
          acc_neg  <= 1'b0;
          base     <= a_mag;
          base_neg <= a_neg;
          e        <= head.b;
        end
      end
      BK_MUL, BK_PACC, BK_PSQ: begin
        pacc <= (pacc << MUL_CHUNK) + PROD_W'(pp);
        my   <= my << MUL_CHUNK;
        cnt  <= cnt + CNT_W'(1);
      end
      BK_MUL_CHK: begin
        fin_value  <= prod_fits ? prod_val : '0;
        fin_status <= prod_fits ? ST_OK : ST_OVF;
      end
      BK_PLOOP: begin
        if (e == '0) begin
          fin_value  <= acc_val;
          fin_status <= ST_OK;
        end else if (e[0]) begin
          mx   <= acc;
          my   <= base;
          mxn  <= acc_neg;
          myn  <= base_neg;
          cnt  <= '0;
          pacc <= '0;
        end
      end
      BK_PACC_CHK: begin
        if (prod_fits) begin
          acc     <= pacc[MAG_W-1:0];
          acc_neg <= prod_neg;
        end else begin
          fin_value  <= '0;
          fin_status <= ST_OVF;
        end
      end
      BK_PSHIFT: begin
        e <= e >> 1;
        if (e[MAG_W-1:1] != '0) begin
          mx   <= base;
          my   <= base;
          mxn  <= base_neg;
          myn  <= base_neg;
          cnt  <= '0;
          pacc <= '0;
        end
      end
      BK_PSQ_CHK: begin
        if (prod_fits) begin
          base     <= pacc[MAG_W-1:0];
          base_neg <= prod_neg;
        end else begin
          fin_value  <= '0;
          fin_status <= ST_OVF;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.status       = out_status;

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |-> (out_value == '0))
    else $error("nonzero result with error status");

  a_chk_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == BK_MUL_CHK) |-> ($past(state) == BK_MUL))
    else $error("multiply check without multiply");

  a_square_needed: assert property (@(posedge clk) disable iff (rst)
    (state == BK_PSQ) |-> (e != '0))
    else $error("squaring after last exponent bit");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != BK_IDLE) |-> !pop)
    else $error("pop while busy");

endmodule

// ===== rtl/checked_int64_alu_with_power.sv =====
// ----------------------------------------------------------------------------
// checked_int64_alu_with_power
// checked signed add, subtract, multiply and power with ok/overflow/invalid
// ----------------------------------------------------------------------------
// One word is executed at a time by the back end; the front end and a short
// queue keep accepting words meanwhile, until the queue is full. Add and
// subtract go from the queue head straight into the result register once
// that register is free. Multiply runs through the shared 64x16 multiplier
// one 16-bit chunk at a time, then a range check and a finish state. Power
// walks the exponent bits from the bottom: each set bit multiplies into the
// accumulator, the base is squared while bits remain, and overflow stops it early.
module checked_int64_alu_with_power #(
  parameter int DATA_WIDTH  = ciap_pkg::DATA_WIDTH_DEF,
  parameter int QUEUE_DEPTH = ciap_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ciap_req_if.sink   req,
  ciap_rsp_if.source rsp
);
  import ciap_pkg::*;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  head_valid, pop;
  item_t head;

  ciap_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ciap_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (head_valid),
    .pop        (pop),
    .pop_item   (head)
  );

  ciap_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule
